FILE: rtl/core/deuc_pkg.sv
// Shared types and constants for the data EEPROM unlock controller.
`default_nettype none

package deuc_pkg;

    // bus access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // register select codes
    localparam logic [1:0] SEL_CTRL = 2'd0;
    localparam logic [1:0] SEL_KEY  = 2'd1;
    localparam logic [1:0] SEL_ADDR = 2'd2;
    localparam logic [1:0] SEL_DATA = 2'd3;

    // unlock key values
    localparam logic [7:0] KEY_ARM    = 8'h55;
    localparam logic [7:0] KEY_UNLOCK = 8'hAA;

    // control register bit positions
    localparam int BIT_RD   = 0;
    localparam int BIT_WR   = 1;
    localparam int BIT_WREN = 2;
    localparam int BIT_CFG  = 7;

    // erased cell value
    localparam logic [7:0] CELL_ERASED = 8'hFF;

    // unlock sequence state; the fourth code never arises
    typedef enum logic [1:0] {
        UNL_LOCKED = 2'd0,
        UNL_OPEN   = 2'd1,
        UNL_ARMED  = 2'd2
    } t_unlock;

    // controller state, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // take the bus request
        logic poll;     // run one controller poll
        logic load;     // move cell read data into data register
        logic emit;     // load the result register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_write;   // latched request is a bus write
        logic reads_cell; // poll will fetch a cell
        logic out_free;   // result register can take a new result
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/core/deuc_ctrl.sv
// Sequencing state machine of the data EEPROM unlock controller.
`default_nettype none

module deuc_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  deuc_pkg::t_dp_status  i_status,
    output deuc_pkg::t_dp_cmd     o_cmd
);
    import deuc_pkg::*;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.is_write && i_status.reads_cell) n_state = S_LOAD;
                else n_state = S_DONE;
            end
            S_LOAD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // commands
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.poll    = (r_state == S_EXEC) && i_status.is_write;
    assign o_cmd.load    = (r_state == S_LOAD);
    assign o_cmd.emit    = (r_state == S_DONE) && i_status.out_free;

endmodule

`default_nettype wire

FILE: rtl/core/deuc_dp.sv
// Register file, cell store, poll logic and result register.
`default_nettype none

module deuc_dp #(
    parameter int STORE_DEPTH = 256
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_action,
    input  wire [1:0]             i_reg_select,
    input  wire [7:0]             i_write_data,
    input  deuc_pkg::t_dp_cmd     i_cmd,
    output deuc_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [7:0]            o_read_data,
    output logic                  o_cell_written
);
    import deuc_pkg::*;

    localparam int IW = $clog2(STORE_DEPTH);

    // bus registers
    logic [7:0] r_ctrl;
    logic [7:0] r_key;
    logic [7:0] r_addr;
    logic [7:0] r_data;
    t_unlock    r_unl;

    // latched request and pending result
    logic       r_is_write;
    logic [7:0] r_rd_data;
    logic       r_wrote;

    // cell store with per-entry written flags
    logic [7:0]             r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [7:0]             r_mem_q;
    logic                   r_mem_v;

    // address to cell index, folded at elaboration
    logic [IW-1:0] w_idx_tab [256];
    logic [IW-1:0] w_idx;

    for (genvar g = 0; g < 256; g++) begin : g_idx
        localparam int unsigned CI = g % STORE_DEPTH;
        assign w_idx_tab[g] = CI[IW-1:0];
    end
    assign w_idx = w_idx_tab[r_addr];

    // selected register for bus reads
    logic [7:0] w_sel_val;
    always_comb begin
        case (i_reg_select)
            SEL_CTRL: w_sel_val = r_ctrl;
            SEL_KEY:  w_sel_val = r_key;
            SEL_ADDR: w_sel_val = r_addr;
            default:  w_sel_val = r_data;
        endcase
    end

    // poll decisions
    logic    w_key_eval;
    t_unlock w_unl_k;
    logic    w_rd_req;
    logic    w_wr_go;
    logic    w_cfg;

    always_comb begin
        w_key_eval = r_ctrl[BIT_WREN] && (r_key != 8'd0);
        w_unl_k    = r_unl;
        if (w_key_eval) begin
            if (r_key == KEY_ARM) w_unl_k = UNL_ARMED;
            else if (r_key == KEY_UNLOCK && r_unl == UNL_ARMED) w_unl_k = UNL_OPEN;
            else w_unl_k = UNL_LOCKED;
        end
        w_rd_req = r_ctrl[BIT_RD];
        w_wr_go  = !r_ctrl[BIT_RD] && r_ctrl[BIT_WR] && (w_unl_k == UNL_OPEN);
        w_cfg    = r_ctrl[BIT_CFG];
    end

    // bus registers and unlock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= 8'd0;
            r_key  <= 8'd0;
            r_addr <= 8'd0;
            r_data <= 8'd0;
            r_unl  <= UNL_LOCKED;
        end else if (i_cmd.capture) begin
            if (i_action == ACT_WRITE) begin
                case (i_reg_select)
                    SEL_CTRL: r_ctrl <= i_write_data;
                    SEL_KEY:  r_key  <= i_write_data;
                    SEL_ADDR: r_addr <= i_write_data;
                    default:  r_data <= i_write_data;
                endcase
            end
        end else if (i_cmd.poll) begin
            if (w_key_eval) r_key <= 8'd0;
            r_unl <= w_unl_k;
            if (w_rd_req) begin
                r_ctrl[BIT_RD] <= 1'b0;
            end else if (w_wr_go) begin
                r_ctrl[BIT_WR] <= 1'b0;
                r_unl          <= UNL_LOCKED;
            end
        end else if (i_cmd.load) begin
            r_data <= r_mem_v ? r_mem_q : CELL_ERASED;
        end
    end

    // request latch and pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_write <= (i_action == ACT_WRITE);
            r_rd_data  <= (i_action == ACT_WRITE) ? 8'd0 : w_sel_val;
            r_wrote    <= 1'b0;
        end else if (i_cmd.poll && w_wr_go && !w_cfg) begin
            r_wrote <= 1'b1;
        end
    end

    // cell store port
    always_ff @(posedge i_clk) begin
        if (i_cmd.poll) begin
            if (w_wr_go && !w_cfg) r_mem[w_idx] <= r_data;
            r_mem_q <= r_mem[w_idx];
            r_mem_v <= r_vld[w_idx];
        end
    end

    // written flags; unwritten cells read as erased
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (i_cmd.poll && w_wr_go && !w_cfg) r_vld[w_idx] <= 1'b1;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_read_data    <= r_rd_data;
            o_cell_written <= r_wrote;
        end
    end

    assign o_status.is_write   = r_is_write;
    assign o_status.reads_cell = w_rd_req && !w_cfg;
    assign o_status.out_free   = !o_out_valid || !i_out_stall;

endmodule

`default_nettype wire

FILE: rtl/core/data_eeprom_unlock_controller_top.sv
// Top level of the data EEPROM unlock controller.
//
// channel  direction  handshake                  payload
// in       slave      i_in_valid / o_in_stall    i_action, i_reg_select, i_write_data
// out      master     o_out_valid / i_out_stall  o_read_data, o_cell_written
//
// A result enters the result register after its request passes the EXEC and DONE
// states, and LOAD as well when a write kicks off a cell read, since the
// single-port cell store read is registered. The input stays stalled until then,
// so a new request is taken only once the last result is in the result register.
// A stalled result holds the next request before its own result. Reset clears bus
// registers, unlock state and cell written flags; cells never written read as erased (0xFF).
`default_nettype none

module data_eeprom_unlock_controller_top #(
    parameter int STORE_DEPTH = 256
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_action,
    input  wire [1:0]  i_reg_select,
    input  wire [7:0]  i_write_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_cell_written
);
    import deuc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    deuc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    deuc_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_action),
        .i_reg_select   (i_reg_select),
        .i_write_data   (i_write_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_cell_written (o_cell_written)
    );

    // a committed cell write comes only from a bus write, which returns zero
    a_written_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cell_written |-> o_read_data == 8'd0)
        else $error("cell write result carries nonzero read data");

    // an accepted request keeps the input stalled in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // a new result appears only while a request is being worked on
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in flight");

    // capture never coincides with poll or load
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.capture && (w_cmd.poll || w_cmd.load)))
        else $error("capture overlaps poll or load");

endmodule

`default_nettype wire
